FILE: rtl/guarded_mac_shift_round_saturate_macros.svh
// Assertion macros for the guarded MAC checker.
// Depends on nothing; included by the checker file.
`ifndef GUARDED_MAC_SHIFT_ROUND_SATURATE_MACROS_SVH
`define GUARDED_MAC_SHIFT_ROUND_SATURATE_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define GMSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define GMSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/gmss_pkg.sv
// Shared types and codes for the guarded MAC with shift-round-saturate.
// No dependencies.
package gmss_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_LOAD       = 3'd1;
    localparam logic [2:0] OP_MAC        = 3'd2;
    localparam logic [2:0] OP_MSU        = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_CLR_STICKY = 3'd5;

    localparam logic [1:0] SH_NONE   = 2'd0;
    localparam logic [1:0] SH_LEFT1  = 2'd1;
    localparam logic [1:0] SH_RIGHT1 = 2'd2;
    localparam logic [1:0] SH_RIGHT2 = 2'd3;

    localparam logic [1:0] RND_TRUNC = 2'd0;
    localparam logic [1:0] RND_HALF  = 2'd1;
    localparam logic [1:0] RND_TZERO = 2'd2;

    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] shift_mode;
        logic [1:0] round_mode;
    } t_ctrl;

endpackage

FILE: rtl/gmss_acc.sv
// Guarded accumulator register: clear, load, multiply-add and multiply-subtract.
// Depends on gmss_pkg.
module gmss_acc #(
    parameter int unsigned GUARD_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  gmss_pkg::t_ctrl                 i_ctrl,
    input  logic signed [31:0]              i_operand_a,
    input  logic signed [63:0]              i_product,
    output logic signed [GUARD_BITS+63:0]   o_acc
);

    localparam int unsigned AccW = GUARD_BITS + 64;

    logic signed [AccW-1:0] r_acc;
    logic signed [AccW-1:0] n_acc;
    logic signed [AccW-1:0] addend;

    // 2*a*b, exact in AccW bits
    assign addend = AccW'(i_product) <<< 1;

    always_comb begin
        case (i_ctrl.opcode)
            gmss_pkg::OP_CLEAR: n_acc = '0;
            gmss_pkg::OP_LOAD:  n_acc = AccW'(i_operand_a) <<< gmss_pkg::WORD_W;
            gmss_pkg::OP_MAC:   n_acc = r_acc + addend;
            gmss_pkg::OP_MSU:   n_acc = r_acc - addend;
            default:            n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/gmss_srs.sv
// Shift, round and saturate view of the guarded accumulator (combinational).
// Depends on gmss_pkg.
module gmss_srs #(
    parameter int unsigned GUARD_BITS = 8
) (
    input  logic signed [GUARD_BITS+63:0]   i_acc,
    input  gmss_pkg::t_ctrl                 i_ctrl,
    output logic [31:0]                     o_result,
    output logic                            o_sat
);

    localparam int unsigned AccW = GUARD_BITS + 64;

    logic signed [AccW-1:0] shifted;
    logic signed [AccW-1:0] base;
    logic signed [AccW-1:0] inc;
    logic signed [AccW-1:0] rounded;
    logic                   orig_neg;
    logic                   pos_ovf;
    logic                   neg_ovf;

    assign orig_neg = i_acc[AccW-1];

    always_comb begin
        case (i_ctrl.shift_mode)
            gmss_pkg::SH_NONE:   shifted = i_acc;
            gmss_pkg::SH_LEFT1:  shifted = i_acc <<< 1;
            gmss_pkg::SH_RIGHT1: shifted = i_acc >>> 1;
            gmss_pkg::SH_RIGHT2: shifted = i_acc >>> 2;
            default:             shifted = i_acc;
        endcase
    end

    // Toward-zero: non-negative drops the low word, negative bumps the high word.
    always_comb begin
        base = shifted;
        inc  = '0;
        case (i_ctrl.round_mode)
            gmss_pkg::RND_HALF: begin
                inc = AccW'(1) <<< (gmss_pkg::WORD_W - 1);
            end
            gmss_pkg::RND_TZERO: begin
                if (orig_neg) begin
                    inc = AccW'(1) <<< gmss_pkg::WORD_W;
                end else begin
                    base = {shifted[AccW-1:gmss_pkg::WORD_W], {gmss_pkg::WORD_W{1'b0}}};
                end
            end
            default: begin
                inc = '0;
            end
        endcase
    end

    assign rounded = base + inc;

    // the guard bits must be a sign extension of bit 63
    assign pos_ovf = !rounded[AccW-1] && (|rounded[AccW-2:2*gmss_pkg::WORD_W-1]);
    assign neg_ovf =  rounded[AccW-1] && !(&rounded[AccW-2:2*gmss_pkg::WORD_W-1]);

    always_comb begin
        if (pos_ovf) begin
            o_result = gmss_pkg::SAT_MAX;
        end else if (neg_ovf) begin
            o_result = gmss_pkg::SAT_MIN;
        end else begin
            o_result = rounded[63:32];
        end
    end

    assign o_sat = pos_ovf | neg_ovf;

endmodule

FILE: rtl/guarded_mac_shift_round_saturate.sv
// Guarded multiply-accumulate unit with shift-round-saturate read-out, top level.
// Depends on gmss_pkg, gmss_acc and gmss_srs.
//
// Takes one request per clock while o_in_stall is low and returns one result per
// request, in order, through the product, accumulator and result registers. The
// accumulator is GUARD_BITS+64 bits, two's complement: guard, high word, low
// word. Opcodes: clear, load (operand_a into the high word, sign-extended into
// the guard, low word zero), multiply-accumulate and multiply-subtract of
// 2*a*b (exact, wrapping at the guard top), read, and clear of the sticky
// saturation flag; codes 6 and 7 behave as read. Every request returns the
// updated accumulator shifted (none, left 1, arithmetic right 1 or 2), rounded
// (truncate, add 2^31, or toward-zero: a non-negative value drops its low word,
// a negative one gets 1 added to its high word) and clipped to 32 bits.
// saturated_now marks a clipped result; saturation_sticky is the flag after
// the request (clear-sticky shows clipping in saturated_now but leaves the flag
// clear). The accumulator itself is never shifted, rounded or clipped.
//
// Pipeline:
//   stage 1  request register
//   stage 2  32x32 signed multiply into a product register
//   stage 3  accumulator update (one wide add or subtract)
//   stage 4  shift/round/saturate of the accumulator into the result register
// The accumulator add/subtract in stage 3 and the sticky flag in stage 4 are the
// only loops, so throughput is one request per clock while the output is not
// stalled. Each stage moves on when the next one is empty or moving, so a
// waiting result does not block requests until every stage is full.
module guarded_mac_shift_round_saturate #(
    parameter int unsigned GUARD_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  logic [1:0]         i_shift_mode,
    input  logic [1:0]         i_round_mode,
    // result side
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result_word,
    output logic               o_saturated_now,
    output logic               o_saturation_sticky
);

    localparam int unsigned AccW = GUARD_BITS + 64;

    // stage valid bits and handshakes
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic n_s1_valid, n_s2_valid, n_s3_valid, n_s4_valid;
    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic mv1, mv2, mv3, mv4;

    // stage payloads
    gmss_pkg::t_ctrl    r_s1_ctrl, r_s2_ctrl, r_s3_ctrl;
    logic signed [31:0] r_s1_operand_a, r_s1_operand_b, r_s2_operand_a;
    logic signed [63:0] r_s2_product;
    logic signed [63:0] n_s2_product;

    logic signed [AccW-1:0] acc;
    logic [31:0]            srs_result;
    logic                   srs_sat;

    logic        r_sticky;
    logic        n_sticky;
    logic [31:0] r_result_word;
    logic        r_saturated_now;

    // ready ripples back from the result register
    assign s4_ready = !r_s4_valid || !i_out_stall;
    assign s3_ready = !r_s3_valid || s4_ready;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    assign mv1 = i_in_valid && s1_ready;
    assign mv2 = r_s1_valid && s2_ready;
    assign mv3 = r_s2_valid && s3_ready;
    assign mv4 = r_s3_valid && s4_ready;

    assign n_s1_valid = mv1 || (r_s1_valid && !mv2);
    assign n_s2_valid = mv2 || (r_s2_valid && !mv3);
    assign n_s3_valid = mv3 || (r_s3_valid && !mv4);
    assign n_s4_valid = mv4 || (r_s4_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
            r_s3_valid <= n_s3_valid;
            r_s4_valid <= n_s4_valid;
        end
    end

    // stage 1: request register
    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_s1_ctrl.opcode     <= i_opcode;
            r_s1_ctrl.shift_mode <= i_shift_mode;
            r_s1_ctrl.round_mode <= i_round_mode;
            r_s1_operand_a       <= i_operand_a;
            r_s1_operand_b       <= i_operand_b;
        end
    end

    // stage 2: full signed product, 64 bits is exact
    assign n_s2_product = r_s1_operand_a * r_s1_operand_b;

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_s2_ctrl      <= r_s1_ctrl;
            r_s2_operand_a <= r_s1_operand_a;
            r_s2_product   <= n_s2_product;
        end
    end

    // stage 3: accumulator; the request sitting in stage 3 sees its own update
    gmss_acc #(
        .GUARD_BITS (GUARD_BITS)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (mv3),
        .i_ctrl      (r_s2_ctrl),
        .i_operand_a (r_s2_operand_a),
        .i_product   (r_s2_product),
        .o_acc       (acc)
    );

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r_s3_ctrl <= r_s2_ctrl;
        end
    end

    // stage 4: read-out view and sticky flag
    gmss_srs #(
        .GUARD_BITS (GUARD_BITS)
    ) u_srs (
        .i_acc    (acc),
        .i_ctrl   (r_s3_ctrl),
        .o_result (srs_result),
        .o_sat    (srs_sat)
    );

    // clear-sticky wins over clipping in the same request
    assign n_sticky = (r_s3_ctrl.opcode == gmss_pkg::OP_CLR_STICKY) ? 1'b0
                                                                     : (r_sticky | srs_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= 1'b0;
        end else if (mv4) begin
            r_sticky <= n_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv4) begin
            r_result_word   <= srs_result;
            r_saturated_now <= srs_sat;
        end
    end

    assign o_in_stall          = !s1_ready;
    assign o_out_valid         = r_s4_valid;
    assign o_result_word       = r_result_word;
    assign o_saturated_now     = r_saturated_now;
    assign o_saturation_sticky = r_sticky;

endmodule

FILE: rtl/gmss_checker.sv
// Port-level checks for the guarded MAC top level, bound to it below.
// Depends on gmss_pkg and guarded_mac_shift_round_saturate_macros.svh.
`include "guarded_mac_shift_round_saturate_macros.svh"

module gmss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_result_word,
    input logic        o_saturated_now,
    input logic        o_saturation_sticky
);

    // reset empties the result register
    `GMSS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a held result keeps its word
    `GMSS_ASSERT(a_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_word), "held result changed")

    // a clipped result is one of the two rails
    `GMSS_ASSERT(a_rail, o_out_valid && o_saturated_now |-> (o_result_word == gmss_pkg::SAT_MAX || o_result_word == gmss_pkg::SAT_MIN), "clip not at rail")

    // the sticky flag only rises with a clipped result
    `GMSS_ASSERT(a_sticky_rise, $rose(o_saturation_sticky) |-> o_out_valid && o_saturated_now, "sticky set without clip")

    // requests are held off only when the result side is backed up
    `GMSS_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall, "request stalled with free output")

endmodule

bind guarded_mac_shift_round_saturate gmss_checker u_gmss_checker (.*);
